[hdl/petb_pkg.sv]
// Package with the types and constants shared by the periodic event timer bank.
package petb_pkg;

   localparam int TIMER_COUNT = 8;
   localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam logic [15:0] RESET_PERIOD = 16'd1024;

   typedef enum logic [2:0] {
      KIND_TICK       = 3'd0,
      KIND_SET_PERIOD = 3'd1,
      KIND_READ_FLAG  = 3'd2,
      KIND_CLEAR_FLAG = 3'd3,
      KIND_WAIT_FLAG  = 3'd4,
      KIND_READ_TIME  = 3'd5
   } kind_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  timer_id;
      logic [15:0] period_value;
   } req_type;

   typedef struct packed {
      logic        flag_value;
      logic [31:0] time_value;
   } rsp_type;

   typedef struct packed {
      logic [15:0] reload_period;
      logic [15:0] countdown;
   } timer_entry_type;

   typedef struct packed {
      logic            rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic            wr_en;
      logic [IDX_W-1:0] wr_addr;
      timer_entry_type wr_data;
   } ram_ctrl_type;

endpackage

[hdl/petb_timer_ram.sv]
// Timer memory holding countdown and reload period, with per-entry valid bits.
module petb_timer_ram (
   input  logic                     clock,
   input  logic                     reset,
   input  petb_pkg::ram_ctrl_type   ctrl,
   output petb_pkg::timer_entry_type rd_data
);
   import petb_pkg::*;

   timer_entry_type        mem [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] valid_ff;
   timer_entry_type        data_ff;
   logic                   hit_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         data_ff <= mem[ctrl.rd_addr];
         hit_ff  <= valid_ff[ctrl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.wr_en) begin
         valid_ff[ctrl.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = hit_ff ? data_ff : timer_entry_type'{RESET_PERIOD, RESET_PERIOD};

endmodule

[hdl/periodic_event_timer_bank.sv]
// Top level of the periodic event timer bank: request decoding, tick walk and flags.
// A request is taken when start is high and busy is low, and its result appears on
// rsp_data with rsp_valid high for exactly one cycle, in the cycle after the request
// completes; the receiver cannot stall it. Set period, flag and time requests complete
// in the cycle in which they are taken, so one may be issued every cycle. A tick walks
// the timer memory one entry per cycle, reading an entry and writing it back in the
// cycle after the read, so its result follows the write-back of the last entry; busy
// is high while the walk runs.
module periodic_event_timer_bank (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  petb_pkg::req_type req_data,
   output logic              rsp_valid,
   output petb_pkg::rsp_type rsp_data
);
   import petb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_TICK = 2'b10
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [31:0]            tick_ff, tick_in;
   logic [TIMER_COUNT-1:0] flag_ff, flag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   ram_ctrl_type           ram_ctrl;
   timer_entry_type        rd_entry;
   timer_entry_type        new_entry;
   logic                   accept;
   logic                   id_ok;
   logic [IDX_W-1:0]       req_idx;
   logic                   tick_done;

   petb_timer_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ram_ctrl),
      .rd_data (rd_entry)
   );

   assign busy      = (state_ff == ST_TICK);
   assign accept    = start && !busy;
   assign id_ok     = {4'b0, req_data.timer_id} < 7'(TIMER_COUNT);
   assign req_idx   = IDX_W'(req_data.timer_id);
   assign tick_done = (state_ff == ST_TICK) && (idx_ff == LAST_IDX);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      tick_in      = tick_ff;
      flag_in      = flag_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '{flag_value: 1'b0, time_value: tick_ff};
      ram_ctrl     = '0;
      new_entry    = rd_entry;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  KIND_TICK: begin
                     ram_ctrl.rd_en   = 1'b1;
                     ram_ctrl.rd_addr = '0;
                     idx_in           = '0;
                     state_in         = ST_TICK;
                  end
                  KIND_SET_PERIOD: begin
                     rsp_valid_in = 1'b1;
                     if (id_ok) begin
                        ram_ctrl.wr_en   = 1'b1;
                        ram_ctrl.wr_addr = req_idx;
                        ram_ctrl.wr_data = '{req_data.period_value, req_data.period_value};
                        flag_in[req_idx] = 1'b0;
                     end
                  end
                  KIND_READ_FLAG: begin
                     rsp_valid_in = 1'b1;
                     if (id_ok) begin
                        rsp_in.flag_value = flag_ff[req_idx];
                     end
                  end
                  KIND_CLEAR_FLAG: begin
                     rsp_valid_in = 1'b1;
                     if (id_ok) begin
                        flag_in[req_idx] = 1'b0;
                     end
                  end
                  KIND_WAIT_FLAG: begin
                     rsp_valid_in = 1'b1;
                     if (id_ok) begin
                        rsp_in.flag_value = flag_ff[req_idx];
                        flag_in[req_idx]  = 1'b0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (rd_entry.countdown != 16'd0) begin
               new_entry.countdown = rd_entry.countdown - 16'd1;
            end else begin
               new_entry.countdown = rd_entry.reload_period;
               flag_in[idx_ff]     = 1'b1;
            end
            ram_ctrl.wr_en   = 1'b1;
            ram_ctrl.wr_addr = idx_ff;
            ram_ctrl.wr_data = new_entry;
            if (tick_done) begin
               tick_in           = tick_ff + 32'd1;
               rsp_valid_in      = 1'b1;
               rsp_in.time_value = tick_ff + 32'd1;
               state_in          = ST_IDLE;
            end else begin
               ram_ctrl.rd_en   = 1'b1;
               ram_ctrl.rd_addr = idx_ff + IDX_W'(1);
               idx_in           = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         tick_ff      <= '0;
         flag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         tick_ff      <= tick_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_short_request: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.kind != KIND_TICK) |=> rsp_valid && !busy)
      else $error("request without tick gave no result in the next cycle");

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.kind == KIND_TICK) |=> busy && !rsp_valid)
      else $error("tick request did not start the timer walk");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      tick_done |=> rsp_valid && (rsp_data.time_value == $past(tick_ff) + 32'd1)
      && !rsp_data.flag_value)
      else $error("tick result missing or time not advanced by one");

   a_time_steady: assert property (@(posedge clock) disable iff (reset)
      !tick_done |=> $stable(tick_ff))
      else $error("tick counter moved outside the end of a tick");

endmodule
